### rtl/core/tagm_pkg.sv
// ----------------------------------------------------------------------------
// tagm_pkg
// Shared types and constants of the tilt angle gesture matcher.
// ----------------------------------------------------------------------------
package tagm_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int CENTER_W   = 11;
    localparam int TARGET_W   = 9;
    localparam int CODE_W     = 8;
    localparam int TOL_W      = 8;
    localparam int ENTRY_W    = 3 * TARGET_W + CODE_W;
    localparam int RAD_W      = 42;
    localparam int ROOT_W     = 21;
    localparam int REM_W      = 24;
    localparam int CORDIC_W   = 26;
    localparam int ANGLE_W    = 16;
    localparam int WIN_W      = 18;
    localparam int STEP_W     = 4;
    localparam int CNT_W      = 5;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CORDIC_STEPS = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = 8'd10;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [1:0] PHASE_X = 2'd0;
    localparam logic [1:0] PHASE_Y = 2'd1;
    localparam logic [1:0] PHASE_Z = 2'd2;

    typedef struct packed {
        logic              add_entry;
        logic              load_sample;
        logic              sq_load;
        logic              sqrt_step;
        logic              cordic_init;
        logic              cordic_step;
        logic              angle_store;
        logic              scan_rd;
        logic              scan_eval;
        logic              flush;
        logic [STEP_W-1:0] step;
        logic [1:0]        phase;
    } tagm_cmd_t;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic [CORDIC_W-1:0] step_angle(input logic [STEP_W-1:0] i);
        logic [CORDIC_W-1:0] a;
        unique case (i)
            4'd0:    a = 26'd2949120;
            4'd1:    a = 26'd1740967;
            4'd2:    a = 26'd919879;
            4'd3:    a = 26'd466945;
            4'd4:    a = 26'd234379;
            4'd5:    a = 26'd117304;
            4'd6:    a = 26'd58666;
            4'd7:    a = 26'd29335;
            4'd8:    a = 26'd14668;
            4'd9:    a = 26'd7334;
            4'd10:   a = 26'd3667;
            4'd11:   a = 26'd1833;
            4'd12:   a = 26'd917;
            4'd13:   a = 26'd458;
            4'd14:   a = 26'd229;
            4'd15:   a = 26'd115;
            default: a = 26'd0;
        endcase
        return a;
    endfunction

endpackage

### rtl/core/tilt_angle_gesture_match.sv
// ----------------------------------------------------------------------------
// tilt_angle_gesture_match
// Accelerometer tilt angle gesture matcher with a table of target motions.
// ----------------------------------------------------------------------------
// An add item (cmd 0) leaves busy low. A sample item (cmd 1) holds busy
// through three passes of a bit-serial square root and a CORDIC unit
// (shared), then one table read per entry plus a final compare and a
// flush. Matches leave on result_valid for one cycle each, in table order,
// with last on the final one, which comes out in the same cycle that busy
// falls; results cannot be held off.
module tilt_angle_gesture_match #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 cmd,
    input  logic [tagm_pkg::SAMPLE_W-1:0]        sample_x,
    input  logic [tagm_pkg::SAMPLE_W-1:0]        sample_y,
    input  logic [tagm_pkg::SAMPLE_W-1:0]        sample_z,
    input  logic signed [tagm_pkg::TARGET_W-1:0] target_x,
    input  logic signed [tagm_pkg::TARGET_W-1:0] target_y,
    input  logic signed [tagm_pkg::TARGET_W-1:0] target_z,
    input  logic [tagm_pkg::CODE_W-1:0]          entry_code,
    input  logic                                 tolerance_we,
    input  logic [tagm_pkg::TOL_W-1:0]           tolerance,
    output logic                                 result_valid,
    output logic [tagm_pkg::CODE_W-1:0]          match_code,
    output logic                                 last
);

    import tagm_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    tagm_cmd_t     dp_cmd;
    logic [CW-1:0] count;
    logic [CW-1:0] scan_idx;

    tagm_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .count    (count),
        .busy     (busy),
        .dp_cmd   (dp_cmd),
        .scan_idx (scan_idx)
    );

    tagm_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .scan_idx     (scan_idx),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .sample_z     (sample_z),
        .target_x     (target_x),
        .target_y     (target_y),
        .target_z     (target_z),
        .entry_code   (entry_code),
        .tolerance_we (tolerance_we),
        .tolerance    (tolerance),
        .count        (count),
        .result_valid (result_valid),
        .match_code   (match_code),
        .last         (last)
    );

endmodule

### rtl/core/tagm_ram.sv
// ----------------------------------------------------------------------------
// tagm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module tagm_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/tagm_ctrl.sv
// ----------------------------------------------------------------------------
// tagm_ctrl
// Sequencer: three root/CORDIC passes, then the table scan and final flush.
// ----------------------------------------------------------------------------
module tagm_ctrl #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   cmd,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]       count,
    output logic                                   busy,
    output tagm_pkg::tagm_cmd_t                    dp_cmd,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]       scan_idx
);

    import tagm_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_SQRT, S_CINIT, S_CORDIC, S_ANGLE, S_SCAN, S_FLUSH
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [1:0]       phase_reg;
    logic [CW-1:0]    idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            phase_reg <= PHASE_X;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && cmd == CMD_SAMPLE)
                    begin
                        phase_reg <= PHASE_X;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    begin
                        state_reg <= S_CINIT;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_CINIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= S_ANGLE;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_ANGLE:
                begin
                    if (phase_reg == PHASE_Z)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 1'b1;
                        state_reg <= S_SQ;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg == count)
                    begin
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_FLUSH:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign scan_idx = idx_reg;

    always_comb
    begin
        dp_cmd             = '0;
        dp_cmd.step        = cnt_reg[STEP_W-1:0];
        dp_cmd.phase       = phase_reg;
        dp_cmd.add_entry   = (state_reg == S_IDLE) && start && (cmd == CMD_ADD);
        dp_cmd.load_sample = (state_reg == S_IDLE) && start && (cmd == CMD_SAMPLE);
        dp_cmd.sq_load     = (state_reg == S_SQ);
        dp_cmd.sqrt_step   = (state_reg == S_SQRT);
        dp_cmd.cordic_init = (state_reg == S_CINIT);
        dp_cmd.cordic_step = (state_reg == S_CORDIC);
        dp_cmd.angle_store = (state_reg == S_ANGLE);
        // entry idx is read while entry idx-1 is compared
        dp_cmd.scan_rd     = (state_reg == S_SCAN) && (idx_reg < count);
        dp_cmd.scan_eval   = (state_reg == S_SCAN) && (idx_reg != '0);
        dp_cmd.flush       = (state_reg == S_FLUSH);
    end

endmodule

### rtl/core/tagm_dp.sv
// ----------------------------------------------------------------------------
// tagm_dp
// Datapath: centering, bit-serial root, CORDIC vectoring, table and window test.
// ----------------------------------------------------------------------------
module tagm_dp #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tagm_pkg::tagm_cmd_t                  dp_cmd,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]     scan_idx,
    input  logic [tagm_pkg::SAMPLE_W-1:0]        sample_x,
    input  logic [tagm_pkg::SAMPLE_W-1:0]        sample_y,
    input  logic [tagm_pkg::SAMPLE_W-1:0]        sample_z,
    input  logic signed [tagm_pkg::TARGET_W-1:0] target_x,
    input  logic signed [tagm_pkg::TARGET_W-1:0] target_y,
    input  logic signed [tagm_pkg::TARGET_W-1:0] target_z,
    input  logic [tagm_pkg::CODE_W-1:0]          entry_code,
    input  logic                                 tolerance_we,
    input  logic [tagm_pkg::TOL_W-1:0]           tolerance,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]     count,
    output logic                                 result_valid,
    output logic [tagm_pkg::CODE_W-1:0]          match_code,
    output logic                                 last
);

    import tagm_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // configuration and table control
    logic [TOL_W-1:0]  tol_reg;
    logic [CW-1:0]     count_reg;
    logic              ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= TOL_RESET;
            count_reg <= '0;
        end
        else
        begin
            if (tolerance_we)
            begin
                tol_reg <= tolerance;
            end
            if (ram_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    assign count     = count_reg;
    assign ram_we    = dp_cmd.add_entry && (count_reg < CW'(MAX_ENTRIES));
    assign ram_wdata = {target_x, target_y, target_z, entry_code};

    tagm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (dp_cmd.scan_rd),
        .raddr (scan_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    // centered readings: 2r - 1023, always odd
    logic signed [CENTER_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [CENTER_W:0]   cx_wide, cy_wide, cz_wide;

    assign cx_wide = $signed({1'b0, sample_x, 1'b0}) - 12'sd1023;
    assign cy_wide = $signed({1'b0, sample_y, 1'b0}) - 12'sd1023;
    assign cz_wide = $signed({1'b0, sample_z, 1'b0}) - 12'sd1023;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_sample)
        begin
            cx_reg <= cx_wide[CENTER_W-1:0];
            cy_reg <= cy_wide[CENTER_W-1:0];
            cz_reg <= cz_wide[CENTER_W-1:0];
        end
    end

    // radicand of the current pass
    logic signed [CENTER_W-1:0]     sq_a, sq_b;
    logic signed [2*CENTER_W-1:0]   sq_aa, sq_bb;
    logic [2*CENTER_W-1:0]          sq_sum;

    always_comb
    begin
        unique case (dp_cmd.phase)
            PHASE_X:
            begin
                sq_a = cy_reg;
                sq_b = cz_reg;
            end
            PHASE_Y:
            begin
                sq_a = cx_reg;
                sq_b = cz_reg;
            end
            default:
            begin
                sq_a = cx_reg;
                sq_b = cy_reg;
            end
        endcase
    end

    assign sq_aa  = sq_a * sq_a;
    assign sq_bb  = sq_b * sq_b;
    assign sq_sum = $unsigned(sq_aa) + $unsigned(sq_bb);

    // restoring square root, one result bit a cycle
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;

    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial     = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (dp_cmd.sq_load)
        begin
            rad_reg  <= {sq_sum[RAD_W-21:0], 20'd0};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (dp_cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // CORDIC vectoring on (den, num)
    logic signed [CORDIC_W-1:0] cx_v_reg, cy_v_reg, cz_v_reg;
    logic signed [CORDIC_W-1:0] root_s, cnum_s, cz_abs_s;
    logic signed [CORDIC_W-1:0] xs, ys, step_a;
    logic signed [CORDIC_W-1:0] z_round;
    logic signed [ANGLE_W-1:0]  angle;
    logic                       neg_z;

    assign root_s   = $signed({{(CORDIC_W-ROOT_W){1'b0}}, root_reg});
    assign cnum_s   = (dp_cmd.phase == PHASE_X)
                      ? $signed({{(CORDIC_W-CENTER_W-10){cx_reg[CENTER_W-1]}}, cx_reg, 10'd0})
                      : $signed({{(CORDIC_W-CENTER_W-10){cy_reg[CENTER_W-1]}}, cy_reg, 10'd0});
    assign neg_z    = cz_reg[CENTER_W-1];
    assign cz_abs_s = neg_z
                      ? -$signed({{(CORDIC_W-CENTER_W-10){cz_reg[CENTER_W-1]}}, cz_reg, 10'd0})
                      : $signed({{(CORDIC_W-CENTER_W-10){cz_reg[CENTER_W-1]}}, cz_reg, 10'd0});

    assign xs     = cx_v_reg >>> dp_cmd.step;
    assign ys     = cy_v_reg >>> dp_cmd.step;
    assign step_a = $signed(step_angle(dp_cmd.step));

    always_ff @(posedge clk)
    begin
        if (dp_cmd.cordic_init)
        begin
            cz_v_reg <= '0;
            if (dp_cmd.phase == PHASE_Z)
            begin
                cx_v_reg <= cz_abs_s;
                cy_v_reg <= root_s;
            end
            else
            begin
                cx_v_reg <= root_s;
                cy_v_reg <= cnum_s;
            end
        end
        else if (dp_cmd.cordic_step)
        begin
            if (!cy_v_reg[CORDIC_W-1])
            begin
                cx_v_reg <= cx_v_reg + ys;
                cy_v_reg <= cy_v_reg - xs;
                cz_v_reg <= cz_v_reg + step_a;
            end
            else
            begin
                cx_v_reg <= cx_v_reg - ys;
                cy_v_reg <= cy_v_reg + xs;
                cz_v_reg <= cz_v_reg - step_a;
            end
        end
    end

    // round 2^-16 degree to 1/64 degree
    assign z_round = cz_v_reg + 26'sd512;
    assign angle   = (dp_cmd.phase == PHASE_Z && neg_z)
                     ? -$signed(z_round[CORDIC_W-1:10])
                     : $signed(z_round[CORDIC_W-1:10]);

    logic signed [ANGLE_W-1:0] ax_reg, ay_reg, az_reg;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.angle_store)
        begin
            unique case (dp_cmd.phase)
                PHASE_X: ax_reg <= angle;
                PHASE_Y: ay_reg <= angle;
                default: az_reg <= angle;
            endcase
        end
    end

    // window test on the entry read last cycle
    logic signed [TARGET_W-1:0] e_tx, e_ty, e_tz;
    logic [CODE_W-1:0]          e_code;
    logic                       hit;

    assign e_tx   = $signed(ram_rdata[ENTRY_W-1 -: TARGET_W]);
    assign e_ty   = $signed(ram_rdata[ENTRY_W-1-TARGET_W -: TARGET_W]);
    assign e_tz   = $signed(ram_rdata[CODE_W+TARGET_W-1 -: TARGET_W]);
    assign e_code = ram_rdata[CODE_W-1:0];

    function automatic logic in_win(input logic signed [ANGLE_W-1:0] ang,
                                    input logic signed [TARGET_W-1:0] tgt,
                                    input logic [TOL_W-1:0] tol);
        logic signed [WIN_W-1:0] t, w, lo, hi, a;
        t  = WIN_W'(tgt);
        w  = $signed({{(WIN_W-TOL_W){1'b0}}, tol});
        lo = (t - w) <<< 6;
        hi = (t + w) <<< 6;
        a  = WIN_W'(ang);
        return (a > lo) && (a < hi);
    endfunction

    assign hit = in_win(ax_reg, e_tx, tol_reg) && in_win(ay_reg, e_ty, tol_reg)
                 && in_win(az_reg, e_tz, tol_reg);

    // one match held back so the final one can carry last
    logic              pend_valid_reg;
    logic [CODE_W-1:0] pend_code_reg;
    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= 1'b0;
            if (dp_cmd.load_sample)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (dp_cmd.scan_eval && hit)
            begin
                pend_valid_reg <= 1'b1;
                out_valid_reg  <= pend_valid_reg;
            end
            else if (dp_cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.scan_eval && hit)
        begin
            pend_code_reg <= e_code;
            out_code_reg  <= pend_code_reg;
            out_last_reg  <= 1'b0;
        end
        else if (dp_cmd.flush)
        begin
            out_code_reg <= pend_code_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign result_valid = out_valid_reg;
    assign match_code   = out_code_reg;
    assign last         = out_last_reg;

endmodule
